@@ sv/nntt_pkg.sv @@
// Shared types and constants of the negacyclic NTT engine.
package nntt_pkg;

   localparam logic [27:0] MODULUS = 28'd268369921;
   localparam logic [27:0] QM1_HALF = 28'd134184960;
   localparam logic [27:0] QM2 = 28'd268369919;

   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_READ = 3'd1;
   localparam logic [2:0] CMD_FWD = 3'd2;
   localparam logic [2:0] CMD_INV = 3'd3;
   localparam logic [2:0] CMD_PREP = 3'd4;

   localparam logic REG_LOG_SIZE = 1'b0;
   localparam logic REG_GEN_ROOT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_MWAIT,
      ST_P_INIT, ST_P_STEP, ST_P_RMUL, ST_P_BMUL,
      ST_T_ZERO, ST_T_ONE, ST_T_FILL, ST_T_WR,
      ST_W_RD, ST_W_MUL, ST_W_WR,
      ST_B_RX, ST_B_RY, ST_B_CALC, ST_B_FWR, ST_B_IWX, ST_B_IWY, ST_B_NEXT,
      ST_S_RD, ST_S_MUL1, ST_S_MUL2, ST_S_WR
   } state_type;

   function automatic logic [27:0] red_once(input logic [28:0] v);
      red_once = (v >= {1'b0, MODULUS}) ? 28'(v - {1'b0, MODULUS}) : v[27:0];
   endfunction

   function automatic logic [27:0] add_mod(input logic [27:0] a, input logic [27:0] b);
      add_mod = red_once({1'b0, a} + {1'b0, b});
   endfunction

   function automatic logic [27:0] sub_mod(input logic [27:0] a, input logic [27:0] b);
      sub_mod = (a >= b) ? (a - b) : 28'({1'b0, a} + {1'b0, MODULUS} - {1'b0, b});
   endfunction

endpackage

@@ sv/negacyclic_ntt_engine.sv @@
// Negacyclic NTT engine: coefficient store, twiddle table and sequencer.
// Usage: req_ words carry a command (write, read, forward, inverse, prepare),
// an index and a value; rsp_ words return read_index and read_value for reads.
// Registers log_size (0x0) and gen_root (0x4) are written via APB; the user
// must write them only while the engine is idle, which the block does not
// enforce; prepare must run after any change to them. A write is stored at
// accept and the engine stays idle; a read word and rsp_valid are registered
// from ST_READ. All products go through one 3-stage modular multiplier
// under a sequencer. Prepare runs two exponentiations then the table fill;
// forward scales each coefficient by its twiddle, then runs the butterfly
// passes; inverse runs them, then scales by the size inverse and twiddles.
// req_ready is low while a command runs or a read word waits; a stalled
// receiver holds the engine until rsp_ready. Reset clears control state,
// size inverse and registers; coefficients and twiddles are undefined until
// written or prepared.
module negacyclic_ntt_engine
   import nntt_pkg::*;
#(
   parameter int MAX_SIZE = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [8:0]  req_coeff_index,
   input  logic [27:0] req_coeff_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_read_index,
   output logic [27:0] rsp_read_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int LOG_MAX = $clog2(MAX_SIZE + 1) - 1;
   localparam int LW = $clog2(LOG_MAX + 1);
   localparam int AW = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
   localparam int TW_DEPTH = 2 * MAX_SIZE + 1;
   localparam int TW_AW = $clog2(TW_DEPTH);
   localparam int CW = $clog2(2 * MAX_SIZE + 2);

   logic [27:0] coef_mem [MAX_SIZE];
   logic [27:0] tw_mem [TW_DEPTH];

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [3:0]  log_size_ff;
   logic [27:0] gen_root_ff;
   logic [LW-1:0] l_ff, l_in, lh_ff, lh_in;
   logic inv_ff, inv_in, sel_ff, sel_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] k_ff, k_in;
   logic [27:0] r_ff, r_in, base_ff, base_in, e_ff, e_in, psi_ff, psi_in;
   logic [27:0] ninv_ff, ninv_in, x_ff, x_in, tw_ff, tw_in, d_ff, d_in;
   logic [8:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_index_ff, rsp_index_in;
   logic [27:0] rsp_value_ff, rsp_value_in;

   logic        mul_go;
   logic [27:0] mul_a, mul_b;
   logic [1:0]  mv_ff;
   logic [55:0] p_ff;
   logic [44:0] f1_ff;
   logic [27:0] res_ff;
   logic [33:0] f2;
   logic [28:0] f3;

   logic          c_we, t_we;
   logic [AW-1:0] c_waddr, c_raddr;
   logic [27:0]   c_wdata, t_wdata, c_rd_ff, t_rd_ff;
   logic [TW_AW-1:0] t_waddr, t_raddr;

   logic [CW-1:0] n_val, n2;
   logic [AW-1:0] hbit, hmask, jlow, xa, ya;
   logic [TW_AW-1:0] twi_f;
   logic [LW-1:0] eff_l;
   logic          accept, cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;
   assign prdata = (paddr[2] == REG_LOG_SIZE) ? {28'd0, log_size_ff} : {4'd0, gen_root_ff};
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_index = rsp_index_ff;
   assign rsp_read_value = rsp_value_ff;

   always_comb begin
      if (log_size_ff == 4'd0) begin
         eff_l = LW'(1);
      end else if (32'(log_size_ff) > LOG_MAX) begin
         eff_l = LW'(LOG_MAX);
      end else begin
         eff_l = LW'(log_size_ff);
      end
   end

   assign n_val = CW'(1) << l_ff;
   assign n2 = n_val << 1;
   assign hbit = AW'(1) << lh_ff;
   assign hmask = hbit - AW'(1);
   assign jlow = k_ff & hmask;
   assign xa = ((k_ff & ~hmask) << 1) | jlow;
   assign ya = xa | hbit;
   assign twi_f = TW_AW'(jlow) << (l_ff - lh_ff);

   // modular multiplier, folding with 2^28 = 2^16 - 1 mod q
   assign f2 = {6'd0, f1_ff[27:0]} + {1'b0, f1_ff[44:28], 16'd0} - {17'd0, f1_ff[44:28]};
   assign f3 = {1'b0, f2[27:0]} + {1'b0, 6'd0, f2[33:28], 16'd0} - {23'd0, f2[33:28]};

   always_ff @(posedge clock) begin
      p_ff <= 56'(mul_a) * 56'(mul_b);
      f1_ff <= {17'd0, p_ff[27:0]} + {1'b0, p_ff[55:28], 16'd0} - {17'd0, p_ff[55:28]};
      res_ff <= red_once(f3);
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         coef_mem[c_waddr] <= c_wdata;
      end
      c_rd_ff <= coef_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         tw_mem[t_waddr] <= t_wdata;
      end
      t_rd_ff <= tw_mem[t_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mv_ff <= 2'd0;
         log_size_ff <= 4'd9;
         gen_root_ff <= 28'd1;
         ninv_ff <= 28'd0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         mv_ff <= {mv_ff[0], mul_go};
         ninv_ff <= ninv_in;
         if (cfg_wr && paddr[2] == REG_LOG_SIZE) begin
            log_size_ff <= pwdata[3:0];
         end
         if (cfg_wr && paddr[2] == REG_GEN_ROOT) begin
            gen_root_ff <= pwdata[27:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;
      lh_ff <= lh_in;
      inv_ff <= inv_in;
      sel_ff <= sel_in;
      cnt_ff <= cnt_in;
      k_ff <= k_in;
      r_ff <= r_in;
      base_ff <= base_in;
      e_ff <= e_in;
      psi_ff <= psi_in;
      x_ff <= x_in;
      tw_ff <= tw_in;
      d_ff <= d_in;
      idx_ff <= idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      l_in = l_ff;
      lh_in = lh_ff;
      inv_in = inv_ff;
      sel_in = sel_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      r_in = r_ff;
      base_in = base_ff;
      e_in = e_ff;
      psi_in = psi_ff;
      ninv_in = ninv_ff;
      x_in = x_ff;
      tw_in = tw_ff;
      d_in = d_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      mul_go = 1'b0;
      mul_a = 28'd0;
      mul_b = 28'd0;
      c_we = 1'b0;
      c_waddr = xa;
      c_wdata = 28'd0;
      c_raddr = xa;
      t_we = 1'b0;
      t_waddr = cnt_ff[TW_AW-1:0];
      t_wdata = 28'd0;
      t_raddr = inv_ff ? (TW_AW'(n2) - twi_f) : twi_f;
      case (state_ff)
         ST_IDLE: begin
            c_raddr = AW'(req_coeff_index);
            idx_in = req_coeff_index;
            if (accept) begin
               l_in = eff_l;
               cnt_in = '0;
               k_in = '0;
               case (req_cmd)
                  CMD_WRITE: begin
                     c_we = 32'(req_coeff_index) < MAX_SIZE;
                     c_waddr = AW'(req_coeff_index);
                     c_wdata = red_once({1'b0, req_coeff_value});
                  end
                  CMD_READ: state_in = ST_READ;
                  CMD_FWD: begin
                     inv_in = 1'b0;
                     state_in = ST_W_RD;
                  end
                  CMD_INV: begin
                     inv_in = 1'b1;
                     lh_in = '0;
                     state_in = ST_B_RX;
                  end
                  CMD_PREP: state_in = ST_P_INIT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = idx_ff;
            rsp_value_in = (32'(idx_ff) < MAX_SIZE) ? c_rd_ff : 28'd0;
            state_in = ST_IDLE;
         end
         ST_MWAIT: begin
            if (mv_ff[1]) begin
               state_in = ret_ff;
            end
         end
         ST_P_INIT: begin
            r_in = 28'd1;
            base_in = 28'(n_val);
            e_in = QM2;
            sel_in = 1'b0;
            state_in = ST_P_STEP;
         end
         ST_P_STEP: begin
            if (e_ff == 28'd0) begin
               if (!sel_ff) begin
                  ninv_in = r_ff;
                  r_in = 28'd1;
                  base_in = red_once({1'b0, gen_root_ff});
                  e_in = QM1_HALF >> l_ff;
                  sel_in = 1'b1;
               end else begin
                  psi_in = r_ff;
                  state_in = ST_T_ZERO;
               end
            end else if (e_ff[0]) begin
               mul_go = 1'b1;
               mul_a = r_ff;
               mul_b = base_ff;
               ret_in = ST_P_RMUL;
               state_in = ST_MWAIT;
            end else begin
               mul_go = 1'b1;
               mul_a = base_ff;
               mul_b = base_ff;
               ret_in = ST_P_BMUL;
               state_in = ST_MWAIT;
            end
         end
         ST_P_RMUL: begin
            r_in = res_ff;
            mul_go = 1'b1;
            mul_a = base_ff;
            mul_b = base_ff;
            ret_in = ST_P_BMUL;
            state_in = ST_MWAIT;
         end
         ST_P_BMUL: begin
            base_in = res_ff;
            e_in = e_ff >> 1;
            state_in = ST_P_STEP;
         end
         ST_T_ZERO: begin
            t_we = 1'b1;
            t_waddr = '0;
            t_wdata = 28'd1;
            state_in = ST_T_ONE;
         end
         ST_T_ONE: begin
            t_we = 1'b1;
            t_waddr = TW_AW'(1);
            t_wdata = psi_ff;
            r_in = psi_ff;
            cnt_in = CW'(2);
            state_in = ST_T_FILL;
         end
         ST_T_FILL: begin
            if (cnt_ff > n2) begin
               state_in = ST_IDLE;
            end else begin
               mul_go = 1'b1;
               mul_a = psi_ff;
               mul_b = r_ff;
               ret_in = ST_T_WR;
               state_in = ST_MWAIT;
            end
         end
         ST_T_WR: begin
            t_we = 1'b1;
            t_wdata = res_ff;
            r_in = res_ff;
            cnt_in = cnt_ff + CW'(1);
            state_in = ST_T_FILL;
         end
         ST_W_RD: begin
            c_raddr = cnt_ff[AW-1:0];
            t_raddr = cnt_ff[TW_AW-1:0];
            state_in = ST_W_MUL;
         end
         ST_W_MUL: begin
            mul_go = 1'b1;
            mul_a = c_rd_ff;
            mul_b = t_rd_ff;
            ret_in = ST_W_WR;
            state_in = ST_MWAIT;
         end
         ST_W_WR: begin
            c_we = 1'b1;
            c_waddr = cnt_ff[AW-1:0];
            c_wdata = res_ff;
            cnt_in = cnt_ff + CW'(1);
            state_in = ST_W_RD;
            if (cnt_ff == n_val - CW'(1)) begin
               lh_in = l_ff - LW'(1);
               state_in = ST_B_RX;
            end
         end
         ST_B_RX: begin
            c_raddr = xa;
            state_in = ST_B_RY;
         end
         ST_B_RY: begin
            c_raddr = ya;
            x_in = c_rd_ff;
            tw_in = t_rd_ff;
            state_in = ST_B_CALC;
         end
         ST_B_CALC: begin
            mul_go = 1'b1;
            mul_b = tw_ff;
            state_in = ST_MWAIT;
            if (!inv_ff) begin
               c_we = 1'b1;
               c_waddr = xa;
               c_wdata = add_mod(x_ff, c_rd_ff);
               mul_a = sub_mod(x_ff, c_rd_ff);
               ret_in = ST_B_FWR;
            end else begin
               mul_a = c_rd_ff;
               ret_in = ST_B_IWX;
            end
         end
         ST_B_FWR: begin
            c_we = 1'b1;
            c_waddr = ya;
            c_wdata = res_ff;
            state_in = ST_B_NEXT;
         end
         ST_B_IWX: begin
            c_we = 1'b1;
            c_waddr = xa;
            c_wdata = add_mod(x_ff, res_ff);
            d_in = sub_mod(x_ff, res_ff);
            state_in = ST_B_IWY;
         end
         ST_B_IWY: begin
            c_we = 1'b1;
            c_waddr = ya;
            c_wdata = d_ff;
            state_in = ST_B_NEXT;
         end
         ST_B_NEXT: begin
            state_in = ST_B_RX;
            if (k_ff == AW'((n_val >> 1) - CW'(1))) begin
               k_in = '0;
               if (!inv_ff) begin
                  if (lh_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     lh_in = lh_ff - LW'(1);
                  end
               end else if (lh_ff == l_ff - LW'(1)) begin
                  cnt_in = '0;
                  state_in = ST_S_RD;
               end else begin
                  lh_in = lh_ff + LW'(1);
               end
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         ST_S_RD: begin
            c_raddr = cnt_ff[AW-1:0];
            t_raddr = TW_AW'(n2 - cnt_ff);
            state_in = ST_S_MUL1;
         end
         ST_S_MUL1: begin
            tw_in = t_rd_ff;
            mul_go = 1'b1;
            mul_a = c_rd_ff;
            mul_b = ninv_ff;
            ret_in = ST_S_MUL2;
            state_in = ST_MWAIT;
         end
         ST_S_MUL2: begin
            mul_go = 1'b1;
            mul_a = res_ff;
            mul_b = tw_ff;
            ret_in = ST_S_WR;
            state_in = ST_MWAIT;
         end
         ST_S_WR: begin
            c_we = 1'b1;
            c_waddr = cnt_ff[AW-1:0];
            c_wdata = res_ff;
            cnt_in = cnt_ff + CW'(1);
            state_in = (cnt_ff == n_val - CW'(1)) ? ST_IDLE : ST_S_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ test/negacyclic_ntt_engine_test.sv @@
// Self-checking testbench for the negacyclic NTT engine: directed table, then random phases.
`timescale 1ns / 1ps

module negacyclic_ntt_engine_test;
   import nntt_pkg::*;

   localparam int          NCOEF = 512;
   localparam int          NPOW = 2 * NCOEF + 1;
   localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
   localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
   localparam logic [2:0]  ADDR_LOG_SIZE = 3'd0;
   localparam logic [2:0]  ADDR_GEN_ROOT = 3'd4;
   localparam logic [27:0] Q_MINUS_1 = MODULUS - 28'd1;
   localparam logic [27:0] ALL_ONES = 28'hfffffff;
   localparam int          PHASES = 10;
   localparam int          PHASE_WORDS = 77;

   typedef struct {
      logic [8:0]  idx;
      logic [27:0] val;
   } coef_read_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [8:0]  idx;
      logic [27:0] val;
      bit          typed;
      logic [27:0] ev;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_cmd;
   logic [8:0]  req_coeff_index;
   logic [27:0] req_coeff_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [8:0]  rsp_read_index;
   logic [27:0] rsp_read_value;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // typed expectation travelling with the word on offer
   bit          word_typed;
   logic [27:0] word_expect;

   int          tx_pct;
   int          rx_pct;
   int          hold_req;
   int          hold_seen;
   int          hold_cycles;
   int          errors;

   coef_read_type pending_reads[$];
   dir_row_type   dir_tab[$];

   // predictor state
   logic [27:0] coef_mem[NCOEF];
   logic [27:0] pow_tab[NPOW];
   logic [27:0] n_inv;
   logic [3:0]  reg_log;
   logic [27:0] reg_root;

   // stimulus-side bookkeeping: legality of reads
   bit          written[NCOEF];

   negacyclic_ntt_engine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_coeff_index(req_coeff_index), .req_coeff_value(req_coeff_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_index(rsp_read_index), .rsp_read_value(rsp_read_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [27:0] mulq(input logic [27:0] a, input logic [27:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return 28'(p % 64'(MODULUS));
   endfunction

   function automatic logic [27:0] addq(input logic [27:0] a, input logic [27:0] b);
      return 28'((64'(a) + 64'(b)) % 64'(MODULUS));
   endfunction

   function automatic logic [27:0] subq(input logic [27:0] a, input logic [27:0] b);
      return (b > a) ? 28'(64'(a) + 64'(MODULUS) - 64'(b)) : a - b;
   endfunction

   function automatic logic [27:0] powq(input logic [27:0] base, input int unsigned e);
      logic [27:0] r;
      logic [27:0] bb;
      r = 28'd1;
      bb = 28'(64'(base) % 64'(MODULUS));
      while (e > 0) begin
         if (e & 1) r = mulq(r, bb);
         e = e >> 1;
         bb = mulq(bb, bb);
      end
      return r;
   endfunction

   function automatic int len_log(input logic [3:0] l);
      int k;
      k = (l < 1) ? 1 : int'(l);
      while (k > 1 && (1 << k) > NCOEF) k--;
      return k;
   endfunction

   function automatic logic [27:0] tw(input int unsigned i);
      return (i < NPOW) ? pow_tab[i] : 28'd0;
   endfunction

   function automatic void build_tables();
      int n;
      n = 1 << len_log(reg_log);
      n_inv = powq(28'(n), int'(MODULUS) - 2);
      pow_tab[0] = 28'd1;
      pow_tab[1] = powq(reg_root, (int'(MODULUS) - 1) / (2 * n));
      for (int i = 2; i <= 2 * n && i < NPOW; i++) pow_tab[i] = mulq(pow_tab[1], pow_tab[i - 1]);
   endfunction

   function automatic void fwd_xform();
      int l;
      int n;
      int b;
      int h;
      logic [27:0] x;
      logic [27:0] y;
      l = len_log(reg_log);
      n = 1 << l;
      b = n;
      for (int i = 0; i < n; i++) coef_mem[i] = mulq(coef_mem[i], tw(i));
      for (int s = 0; s < l; s++) begin
         h = b / 2;
         for (int i = 0; i < n; i += b) begin
            for (int j = 0; j < h; j++) begin
               x = coef_mem[i + j];
               y = coef_mem[i + j + h];
               coef_mem[i + j] = addq(x, y);
               coef_mem[i + j + h] = mulq(subq(x, y), tw(j * (2 * n / b)));
            end
         end
         b = b / 2;
      end
   endfunction

   function automatic void inv_xform();
      int l;
      int n;
      int b;
      int h;
      logic [27:0] x;
      logic [27:0] y;
      l = len_log(reg_log);
      n = 1 << l;
      b = 2;
      for (int s = 0; s < l; s++) begin
         h = b / 2;
         for (int i = 0; i < n; i += b) begin
            for (int j = 0; j < h; j++) begin
               x = coef_mem[i + j];
               y = mulq(coef_mem[i + j + h], tw(2 * n - j * (2 * n / b)));
               coef_mem[i + j] = addq(x, y);
               coef_mem[i + j + h] = subq(x, y);
            end
         end
         b = b * 2;
      end
      for (int i = 0; i < n; i++) coef_mem[i] = mulq(mulq(coef_mem[i], n_inv), tw(2 * n - i));
   endfunction

   // predictor and checker, sampling at the clock edge
   always @(posedge clock) begin
      coef_read_type got;
      coef_read_type want;
      if (reset) begin
         errors = 0;
         for (int i = 0; i < NCOEF; i++) coef_mem[i] = '0;
         for (int i = 0; i < NPOW; i++) pow_tab[i] = '0;
         n_inv = '0;
         reg_log = 4'd9;
         reg_root = 28'd1;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_LOG_SIZE) reg_log = pwdata[3:0];
            else if (paddr == ADDR_GEN_ROOT) reg_root = pwdata[27:0];
         end
         if (rsp_valid && rsp_ready) begin
            got.idx = rsp_read_index;
            got.val = rsp_read_value;
            if (pending_reads.size() == 0) begin
               $error("unexpected word: read_index %0d read_value %0d", got.idx, got.val);
               errors++;
            end else begin
               want = pending_reads.pop_front();
               if (got.idx !== want.idx) begin
                  $error("read_index: expected %0d, got %0d", want.idx, got.idx);
                  errors++;
               end
               if (got.val !== want.val) begin
                  $error("read_value: expected %0d, got %0d", want.val, got.val);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_cmd)
               CMD_WRITE: coef_mem[req_coeff_index] = 28'(64'(req_coeff_value) % 64'(MODULUS));
               CMD_READ: begin
                  want.idx = req_coeff_index;
                  want.val = word_typed ? word_expect : coef_mem[req_coeff_index];
                  pending_reads.push_back(want);
               end
               CMD_FWD: fwd_xform();
               CMD_INV: inv_xform();
               CMD_PREP: build_tables();
               default: ;
            endcase
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_seen = 0;
         hold_cycles = 0;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_cycles = 400;
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_pct);
      end
   end

   task automatic put_word(input logic [2:0] c, input logic [8:0] i, input logic [27:0] v,
                           input bit typed, input logic [27:0] ev);
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_coeff_index <= i;
      req_coeff_value <= v;
      word_typed <= typed;
      word_expect <= ev;
      if (c == CMD_WRITE) written[i] = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_write(input logic [2:0] a, input logic [31:0] d);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= a;
      pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_reads();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reads.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic void row(input logic [2:0] c, input logic [8:0] i, input logic [27:0] v,
                               input bit typed, input logic [27:0] ev);
      dir_row_type r;
      r.cmd = c;
      r.idx = i;
      r.val = v;
      r.typed = typed;
      r.ev = ev;
      dir_tab.push_back(r);
   endfunction

   function automatic logic [27:0] pick_val();
      case ($urandom_range(9))
         0: return 28'd0;
         1: return Q_MINUS_1;
         2: return ALL_ONES;
         3: return MODULUS;
         default: return 28'($urandom());
      endcase
   endfunction

   initial begin
      logic [3:0]  log_list[PHASES];
      logic [27:0] root_list[PHASES];
      int          n;
      int          lg;
      int          words;
      int          op;
      int          xf_pct;
      logic [8:0]  ix;

      log_list = '{4'd1, 4'd2, 4'd3, 4'd9, 4'd0, 4'd4, 4'd15, 4'd5, 4'd8, 4'd6};
      root_list = '{28'd1, Q_MINUS_1, ALL_ONES, 28'd3, 28'd17, 28'd0, 28'd0, 28'd7, 28'd0, 28'd0};

      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_WRITE;
      req_coeff_index = '0;
      req_coeff_value = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      word_typed = 1'b0;
      word_expect = '0;
      tx_pct = 0;
      rx_pct = 0;
      hold_req = 0;
      for (int i = 0; i < NCOEF; i++) written[i] = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at n = 4
      csr_write(ADDR_LOG_SIZE, 32'd2);
      csr_write(ADDR_GEN_ROOT, 32'd11);
      row(CMD_WRITE, 9'd0, 28'd0, 0, 0);
      row(CMD_READ, 9'd0, 28'd0, 1, 28'd0);
      row(CMD_WRITE, 9'd511, ALL_ONES, 0, 0);
      row(CMD_READ, 9'd511, 28'd0, 1, ALL_ONES - MODULUS);
      row(CMD_WRITE, 9'd1, Q_MINUS_1, 0, 0);
      row(CMD_READ, 9'd1, ALL_ONES, 1, Q_MINUS_1);
      row(CMD_WRITE, 9'd2, 28'd1234567, 0, 0);
      row(CMD_WRITE, 9'd3, MODULUS, 0, 0);
      row(CMD_READ, 9'd3, 28'd0, 1, 28'd0);
      row(CMD_WRITE, 9'd3, 28'd200000000, 0, 0);
      row(CMD_SPARE_LO, 9'd5, ALL_ONES, 0, 0);
      row(CMD_SPARE_HI, 9'd511, 28'd0, 0, 0);
      row(3'd6, 9'd0, 28'd1, 0, 0);
      row(CMD_PREP, 9'd0, 28'd0, 0, 0);
      row(CMD_FWD, 9'd0, 28'd0, 0, 0);
      for (int i = 0; i < 4; i++) row(CMD_READ, 9'(i), 28'd0, 0, 0);
      row(CMD_INV, 9'd0, 28'd0, 0, 0);
      for (int i = 0; i < 4; i++) row(CMD_READ, 9'(i), 28'd0, 0, 0);
      foreach (dir_tab[k]) put_word(dir_tab[k].cmd, dir_tab[k].idx, dir_tab[k].val,
                                     dir_tab[k].typed, dir_tab[k].ev);
      drain_reads();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin tx_pct = 0; rx_pct = 0; end
            1: begin tx_pct = 73; rx_pct = 0; end
            2: begin tx_pct = 0; rx_pct = 73; end
            default: begin tx_pct = 13; rx_pct = 13; end
         endcase
         if (root_list[ph] == 28'd0) root_list[ph] = 28'($urandom_range(2, int'(Q_MINUS_1)));
         csr_write(ADDR_LOG_SIZE, {28'($urandom()), log_list[ph]});
         csr_write(ADDR_GEN_ROOT, {4'($urandom()), root_list[ph]});
         lg = len_log(reg_log);
         n = 1 << lg;
         xf_pct = (lg >= 7) ? 1 : 8;
         put_word(CMD_PREP, 9'($urandom()), 28'($urandom()), 0, 0);
         for (int k = 0; k < n; k++) put_word(CMD_WRITE, 9'(k), pick_val(), 0, 0);
         if (ph == 2) begin
            hold_req++;
            for (int k = 0; k < 24; k++) put_word(CMD_READ, 9'($urandom_range(n - 1)), 28'($urandom()), 0, 0);
         end
         words = (PHASE_WORDS - n > 20) ? PHASE_WORDS - n : 20;
         for (int k = 0; k < words; k++) begin
            if (ph == 5 && k == words / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_reads.size() > 0) @(posedge clock);
            end
            op = $urandom_range(99);
            ix = 9'($urandom());
            if (op < 38) begin
               put_word(CMD_WRITE, ix, pick_val(), 0, 0);
            end else if (op < 75) begin
               if (!written[ix]) ix = 9'($urandom_range(n - 1));
               put_word(CMD_READ, ix, 28'($urandom()), 0, 0);
            end else if (op < 75 + xf_pct) begin
               put_word(CMD_FWD, ix, 28'($urandom()), 0, 0);
            end else if (op < 75 + 2 * xf_pct) begin
               put_word(CMD_INV, ix, 28'($urandom()), 0, 0);
            end else if (op < 95 - xf_pct && lg < 7) begin
               put_word(CMD_PREP, ix, 28'($urandom()), 0, 0);
            end else begin
               put_word(3'($urandom_range(int'(CMD_SPARE_HI), int'(CMD_SPARE_LO))), ix,
                        28'($urandom()), 0, 0);
            end
         end
         put_word(CMD_READ, 9'd0, 28'd0, 0, 0);
         drain_reads();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && pending_reads.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
